// File: src/lrpf_pkg.sv
// Shared constants, operation codes, sequencer states and the walk descriptor of the frame store.
package lrpf_pkg;

	localparam int COLUMNS   = 128;
	localparam int COL_W     = 7;
	localparam int PAGES_DEF = 8;
	localparam int COORD_W   = 8;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int ERR_W     = 12;
	localparam int IDX_W     = 10;
	localparam int BYTE_W    = 8;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_SET   = 2'd1,
		OP_LINE  = 2'd2,
		OP_READ  = 2'd3
	} lrpf_op_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLEAR = 6'b000010,
		S_PIX   = 6'b000100,
		S_RMW   = 6'b001000,
		S_READ  = 6'b010000,
		S_DONE  = 6'b100000
	} lrpf_state_t;

	// Constant description of one line walk, fixed when the item is accepted.
	typedef struct packed {
		logic               steep;
		logic               x_dec;
		logic               y_dec;
		logic [DIFF_W-1:0]  dx2;
		logic [DIFF_W-1:0]  dy2;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
	} lrpf_walk_t;

endpackage

// File: src/lrpf_store.sv
// Frame store memory: one write port and one registered read port.
module lrpf_store #(
	parameter int PAGES = lrpf_pkg::PAGES_DEF
) (
	input  logic                                            clk,
	input  logic                                            wr_en,
	input  logic [$clog2(PAGES*lrpf_pkg::COLUMNS)-1:0]      wr_addr,
	input  logic [lrpf_pkg::BYTE_W-1:0]                     wr_data,
	input  logic [$clog2(PAGES*lrpf_pkg::COLUMNS)-1:0]      rd_addr,
	output logic [lrpf_pkg::BYTE_W-1:0]                     rd_data
);
	import lrpf_pkg::*;

	localparam int DEPTH = PAGES * COLUMNS;

	logic [BYTE_W-1:0] bytes_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bytes_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= bytes_q[rd_addr];
	end

endmodule

// File: src/lrpf_step.sv
// Bresenham step unit: advances one coordinate pair and the error term.
module lrpf_step (
	input  lrpf_pkg::lrpf_walk_t                   walk,
	input  logic [lrpf_pkg::COORD_W-1:0]           x_cur,
	input  logic [lrpf_pkg::COORD_W-1:0]           y_cur,
	input  logic signed [lrpf_pkg::ERR_W-1:0]      err_cur,
	output logic [lrpf_pkg::COORD_W-1:0]           x_nxt,
	output logic [lrpf_pkg::COORD_W-1:0]           y_nxt,
	output logic signed [lrpf_pkg::ERR_W-1:0]      err_nxt,
	output logic                                   at_end
);
	import lrpf_pkg::*;

	logic signed [ERR_W-1:0] dx2_e;
	logic signed [ERR_W-1:0] dy2_e;
	logic [COORD_W-1:0]      x_adv;
	logic [COORD_W-1:0]      y_adv;

	always_comb begin
		dx2_e = $signed({{(ERR_W-DIFF_W){1'b0}}, walk.dx2});
		dy2_e = $signed({{(ERR_W-DIFF_W){1'b0}}, walk.dy2});
		x_adv = walk.x_dec ? x_cur - COORD_W'(1) : x_cur + COORD_W'(1);
		y_adv = walk.y_dec ? y_cur - COORD_W'(1) : y_cur + COORD_W'(1);
		if (walk.steep) begin
			// The row always moves; the column moves when the error has run out.
			at_end = (y_cur == walk.y_end);
			y_nxt  = y_adv;
			if (err_cur <= 0) begin
				x_nxt   = x_adv;
				err_nxt = err_cur + dy2_e - dx2_e;
			end else begin
				x_nxt   = x_cur;
				err_nxt = err_cur - dx2_e;
			end
		end else begin
			at_end = (x_cur == walk.x_end);
			x_nxt  = x_adv;
			if (err_cur >= 0) begin
				y_nxt   = y_adv;
				err_nxt = err_cur - dx2_e + dy2_e;
			end else begin
				y_nxt   = y_cur;
				err_nxt = err_cur + dy2_e;
			end
		end
	end

endmodule

// File: src/line_raster_page_framebuffer.sv
// Top level of the paged monochrome frame store with pixel set, line draw, clear and byte read.
// A clear writes zero to every byte in turn; a read fetches one byte; a set pixel reads and
// writes back one byte, or is refused without touching the store when the pixel is out of
// range. A line visits its pixels in turn, reading and writing back each one inside the store
// and stepping over those outside; one item is worked on at a time, and the next is taken
// only after the result is posted. Reset is asynchronous; after it the store is cleared by a
// pass over all PAGES*COLUMNS bytes (1024 at the default) during which req_stall stays high.
module line_raster_page_framebuffer #(
	parameter int PAGES = lrpf_pkg::PAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [1:0]                           op,
	input  logic [lrpf_pkg::COORD_W-1:0]         x_start,
	input  logic [lrpf_pkg::COORD_W-1:0]         y_start,
	input  logic [lrpf_pkg::COORD_W-1:0]         x_end,
	input  logic [lrpf_pkg::COORD_W-1:0]         y_end,
	input  logic [lrpf_pkg::IDX_W-1:0]           read_index,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [lrpf_pkg::BYTE_W-1:0]          read_byte,
	output logic                                 status
);
	import lrpf_pkg::*;

	localparam int ROWS   = PAGES * 8;
	localparam int DEPTH  = PAGES * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PG_W   = ADDR_W - COL_W;

	lrpf_state_t             state_q;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic                    clr_op_q;
	lrpf_walk_t              walk_q;
	logic [COORD_W-1:0]      x_q;
	logic [COORD_W-1:0]      y_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    rd_ok_q;
	logic [BYTE_W-1:0]       res_byte_q;
	logic                    res_status_q;
	logic                    rsp_valid_q;
	logic [BYTE_W-1:0]       read_byte_q;
	logic                    status_q;

	// Line setup values, worked out from the request fields at acceptance.
	logic [COORD_W-1:0]      xe_in;
	logic [COORD_W-1:0]      ye_in;
	logic signed [COORD_W:0] ddx;
	logic signed [COORD_W:0] ddy;
	logic [COORD_W-1:0]      adx;
	logic [COORD_W-1:0]      ady;
	logic                    steep_in;
	lrpf_walk_t              walk_in;
	logic signed [ERR_W-1:0] err_in;
	logic                    start_ok;

	// Current pixel and its store address.
	logic                    pix_ok;
	logic [ADDR_W-1:0]       pix_addr;

	logic [COORD_W-1:0]      x_nxt;
	logic [COORD_W-1:0]      y_nxt;
	logic signed [ERR_W-1:0] err_nxt;
	logic                    at_end;

	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic [BYTE_W-1:0]       wr_data;
	logic [ADDR_W-1:0]       rd_addr;
	logic [BYTE_W-1:0]       rd_data;

	// A set pixel request is walked as a line whose end equals its start, which plots
	// exactly the start pixel and stops.
	always_comb begin
		xe_in    = (op == OP_SET) ? x_start : x_end;
		ye_in    = (op == OP_SET) ? y_start : y_end;
		ddx      = $signed({1'b0, xe_in}) - $signed({1'b0, x_start});
		ddy      = $signed({1'b0, ye_in}) - $signed({1'b0, y_start});
		adx      = ddx[COORD_W] ? COORD_W'(-ddx) : COORD_W'(ddx);
		ady      = ddy[COORD_W] ? COORD_W'(-ddy) : COORD_W'(ddy);
		// Equal slopes take the steep branch, so a diagonal walks by rows.
		steep_in = !(ady < adx);
		walk_in.steep = steep_in;
		walk_in.x_dec = ddx[COORD_W];
		walk_in.y_dec = ddy[COORD_W];
		walk_in.dx2   = {adx, 1'b0};
		walk_in.dy2   = {ady, 1'b0};
		walk_in.x_end = xe_in;
		walk_in.y_end = ye_in;
		if (steep_in) begin
			err_in = ERR_W'(ady) - ERR_W'(walk_in.dx2);
		end else begin
			err_in = ERR_W'(walk_in.dy2) - ERR_W'(adx);
		end
		start_ok = (x_start < COORD_W'(COLUMNS)) && (y_start < COORD_W'(ROWS));
	end

	// Pixels off the store are walked over without touching memory.
	always_comb begin
		pix_ok   = (x_q < COORD_W'(COLUMNS)) && (y_q < COORD_W'(ROWS));
		pix_addr = {y_q[3 +: PG_W], x_q[COL_W-1:0]};
	end

	lrpf_step u_step (
		.walk    (walk_q),
		.x_cur   (x_q),
		.y_cur   (y_q),
		.err_cur (err_q),
		.x_nxt   (x_nxt),
		.y_nxt   (y_nxt),
		.err_nxt (err_nxt),
		.at_end  (at_end)
	);

	// Write port: clear sweep and pixel write-back. Read port: pixel and byte reads.
	always_comb begin
		wr_en   = (state_q == S_CLEAR) || (state_q == S_RMW);
		wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : pix_addr;
		wr_data = (state_q == S_CLEAR) ? '0 : (rd_data | (BYTE_W'(1) << y_q[2:0]));
		rd_addr = (state_q == S_IDLE) ? read_index[ADDR_W-1:0] : pix_addr;
	end

	lrpf_store #(
		.PAGES (PAGES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer. Items are taken only in IDLE; a finished result waits in DONE until the
	// output register is free, so the next item may be taken while a result is still held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			clr_op_q     <= 1'b0;
			walk_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			err_q        <= '0;
			rd_ok_q      <= 1'b0;
			res_byte_q   <= '0;
			res_status_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			read_byte_q  <= '0;
			status_q     <= 1'b0;
		end else begin
			// The output register is loaded from DONE when it is free or being taken,
			// otherwise it empties once its item is taken.
			if (state_q == S_DONE) begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_q <= 1'b1;
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						res_byte_q   <= '0;
						res_status_q <= 1'b0;
						walk_q       <= walk_in;
						x_q          <= x_start;
						y_q          <= y_start;
						err_q        <= err_in;
						rd_ok_q      <= ({1'b0, read_index} < (IDX_W+1)'(DEPTH));
						case (op)
							OP_CLEAR: begin
								clr_cnt_q <= '0;
								clr_op_q  <= 1'b1;
								state_q   <= S_CLEAR;
							end
							OP_SET: begin
								if (start_ok) begin
									state_q <= S_PIX;
								end else begin
									res_status_q <= 1'b1;
									state_q      <= S_DONE;
								end
							end
							OP_LINE: begin
								state_q <= S_PIX;
							end
							OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						// The sweep after reset returns to IDLE without producing a result.
						state_q  <= clr_op_q ? S_DONE : S_IDLE;
						clr_op_q <= 1'b0;
					end
				end
				S_PIX: begin
					if (pix_ok) begin
						state_q <= S_RMW;
					end else if (at_end) begin
						state_q <= S_DONE;
					end else begin
						x_q   <= x_nxt;
						y_q   <= y_nxt;
						err_q <= err_nxt;
					end
				end
				S_RMW: begin
					if (at_end) begin
						state_q <= S_DONE;
					end else begin
						x_q     <= x_nxt;
						y_q     <= y_nxt;
						err_q   <= err_nxt;
						state_q <= S_PIX;
					end
				end
				S_READ: begin
					res_byte_q <= rd_ok_q ? rd_data : '0;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						read_byte_q <= res_byte_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign read_byte = read_byte_q;
	assign status    = status_q;

endmodule

// File: src/lrpf_chk.sv
// Port-level checker for the frame store and its bind to the top level.
module lrpf_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_stall,
	input logic [1:0]                           op,
	input logic [lrpf_pkg::COORD_W-1:0]         x_start,
	input logic [lrpf_pkg::COORD_W-1:0]         y_start,
	input logic [lrpf_pkg::COORD_W-1:0]         x_end,
	input logic [lrpf_pkg::COORD_W-1:0]         y_end,
	input logic [lrpf_pkg::IDX_W-1:0]           read_index,
	input logic                                 rsp_valid,
	input logic                                 rsp_stall,
	input logic [lrpf_pkg::BYTE_W-1:0]          read_byte,
	input logic                                 status
);
	import lrpf_pkg::*;

	// One item at a time: the block is busy right after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while an item was still in work");

	// A clear sweeps the whole store, so the block stays busy after it takes one.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (op == OP_CLEAR) |=> req_stall ##1 req_stall)
		else $error("clear finished too early");

	// A waiting request keeps its valid and its fields until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid
			&& $stable({op, x_start, y_start, x_end, y_end, read_index}))
		else $error("stalled request changed");

	// Only a rejected set pixel reports status, and it never carries a byte.
	a_status_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> (read_byte == '0))
		else $error("error result carries a nonzero byte");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_byte) && $stable(status))
		else $error("stalled result changed");

endmodule

bind line_raster_page_framebuffer lrpf_chk u_lrpf_chk (.*);

// File: sim/tb.sv
// Self-checking testbench for the paged frame store with pixel set, line draw, clear and byte read.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrpf_pkg::*;

	// The block runs at its default size of eight pages of 128 columns.
	localparam int ROWS        = PAGES_DEF * 8;
	localparam int STORE_BYTES = PAGES_DEF * COLUMNS;

	// The slowest item is a clear, which sweeps every byte of the store; a long line visits
	// each of its pixels in turn. With the mix below and the longest gaps on both sides,
	// a correct run stays well under this limit, so the limit only catches a hang.
	localparam int CYCLE_LIMIT = 2_000_000;

	// One input item, as the sender presents it.
	typedef struct {
		lrpf_op_t            op;
		logic [COORD_W-1:0]  x_start;
		logic [COORD_W-1:0]  y_start;
		logic [COORD_W-1:0]  x_end;
		logic [COORD_W-1:0]  y_end;
		logic [IDX_W-1:0]    read_index;
	} raster_req_t;

	// One result item, as the block returns it.
	typedef struct {
		logic [BYTE_W-1:0] read_byte;
		logic              status;
	} raster_rsp_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [1:0]          op = OP_READ;
	logic [COORD_W-1:0]  x_start = '0;
	logic [COORD_W-1:0]  y_start = '0;
	logic [COORD_W-1:0]  x_end = '0;
	logic [COORD_W-1:0]  y_end = '0;
	logic [IDX_W-1:0]    read_index = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [BYTE_W-1:0]   read_byte;
	logic                status;

	// Our own copy of the frame store, updated as each item is accepted.
	logic [BYTE_W-1:0] frame_model [0:STORE_BYTES-1];

	// Results that the block owes us, oldest first.
	raster_rsp_t awaited_results [$];

	int unsigned cycle_count = 0;
	int          fail_count = 0;
	int          checked_count = 0;
	int          clear_count = 0;
	int          set_count = 0;
	int          reject_count = 0;
	int          line_count = 0;
	int          read_count = 0;

	// When this is low, neither side inserts gaps, so back-to-back traffic is seen too.
	bit idle_enabled = 1'b1;

	// Corners of the most recent in-range drawing, so that reads can land on fresh pixels.
	int last_xa = 0, last_xb = 0, last_ya = 0, last_yb = 0;

	line_raster_page_framebuffer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.read_index (read_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_byte  (read_byte),
		.status     (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Sets one pixel of the model store. Pixels outside the store are refused, and the
	// caller decides whether that matters: it does for a single pixel, not for a line.
	function automatic bit plot_pixel(int x, int y);
		int idx;
		if (x < 0 || x > COLUMNS - 1 || y < 0 || y >= ROWS) begin
			return 1'b0;
		end
		idx = (y >> 3) * COLUMNS + x;
		frame_model[idx][y & 7] = 1'b1;
		return 1'b1;
	endfunction

	// Bresenham walk from (xa, ya) to (xb, yb). The shallow branch steps in x and is
	// taken only when the rise is strictly smaller than the run, so an exact diagonal
	// goes down the steep branch.
	function automatic void raster_line(int xa, int ya, int xb, int yb);
		int dx, dy, sx, sy, d;
		dx = xb - xa;
		dy = yb - ya;
		sx = 1;
		sy = 1;
		if (dx < 0) begin
			dx = -dx;
			sx = -1;
		end
		if (dy < 0) begin
			dy = -dy;
			sy = -1;
		end
		void'(plot_pixel(xa, ya));
		if (dy < dx) begin
			d = 2 * dy - dx;
			while (xa != xb) begin
				xa += sx;
				if (d >= 0) begin
					ya += sy;
					d -= 2 * dx;
				end
				d += 2 * dy;
				void'(plot_pixel(xa, ya));
			end
		end else begin
			d = dy - 2 * dx;
			while (ya != yb) begin
				ya += sy;
				if (d <= 0) begin
					xa += sx;
					d += 2 * dy;
				end
				d -= 2 * dx;
				void'(plot_pixel(xa, ya));
			end
		end
	endfunction

	// Applies one accepted item to the model store and returns the result it must give.
	function automatic raster_rsp_t apply_operation(raster_req_t req);
		raster_rsp_t rsp;
		rsp.read_byte = '0;
		rsp.status = 1'b0;
		case (req.op)
			OP_CLEAR: begin
				foreach (frame_model[i]) frame_model[i] = '0;
				clear_count++;
			end
			OP_SET: begin
				if (!plot_pixel(req.x_start, req.y_start)) begin
					rsp.status = 1'b1;
					reject_count++;
				end
				set_count++;
			end
			OP_LINE: begin
				raster_line(req.x_start, req.y_start, req.x_end, req.y_end);
				line_count++;
			end
			default: begin
				if (req.read_index < STORE_BYTES) begin
					rsp.read_byte = frame_model[req.read_index];
				end
				read_count++;
			end
		endcase
		return rsp;
	endfunction

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_enabled || r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Presents one item, holds it until it is taken, records what it must produce and
	// then maybe leaves a gap. Valid stays high straight into the next item when there
	// is no gap, so it is never dropped and raised in the same step.
	task automatic send_item(raster_req_t req);
		int gap;
		@(negedge clk);
		op = req.op;
		x_start = req.x_start;
		y_start = req.y_start;
		x_end = req.x_end;
		y_end = req.y_end;
		read_index = req.read_index;
		req_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		awaited_results.push_back(apply_operation(req));
		gap = gap_cycles();
		if (gap > 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Builds an item of the given operation; each field given as a negative number takes a random value, so the
	// block is also seen to ignore the fields that an operation does not use.
	function automatic raster_req_t make_item(lrpf_op_t kind, int xs, int ys, int xe, int ye,
			int idx);
		raster_req_t req;
		req.op = kind;
		req.x_start = (xs < 0) ? COORD_W'($urandom) : COORD_W'(xs);
		req.y_start = (ys < 0) ? COORD_W'($urandom) : COORD_W'(ys);
		req.x_end = (xe < 0) ? COORD_W'($urandom) : COORD_W'(xe);
		req.y_end = (ye < 0) ? COORD_W'($urandom) : COORD_W'(ye);
		req.read_index = (idx < 0) ? IDX_W'($urandom) : IDX_W'(idx);
		return req;
	endfunction

	// Right after reset the clearing pass must leave every byte zero.
	task automatic test_reset_state();
		send_item(make_item(OP_READ, -1, -1, -1, -1, 0));
		send_item(make_item(OP_READ, -1, -1, -1, -1, STORE_BYTES - 1));
		send_item(make_item(OP_READ, -1, -1, -1, -1, 517));
	endtask

	// Single pixels at the corners, and the three ways a pixel can miss the store:
	// column too large, row exactly one past the last, and both fields at their maximum.
	task automatic test_pixel_set();
		send_item(make_item(OP_SET, 0, 0, -1, -1, -1));
		send_item(make_item(OP_SET, COLUMNS - 1, ROWS - 1, -1, -1, -1));
		send_item(make_item(OP_SET, COLUMNS - 1, 0, -1, -1, -1));
		send_item(make_item(OP_SET, COLUMNS, 5, -1, -1, -1));
		send_item(make_item(OP_SET, 3, ROWS, -1, -1, -1));
		send_item(make_item(OP_SET, 255, 255, -1, -1, -1));
		send_item(make_item(OP_READ, -1, -1, -1, -1, 0));
		send_item(make_item(OP_READ, -1, -1, -1, -1, STORE_BYTES - 1));
		send_item(make_item(OP_READ, -1, -1, -1, -1, COLUMNS - 1));
	endtask

	// Lines of every shape: a single point, shallow, steep, an exact diagonal, one drawn
	// backwards, one that starts outside the store and enters it, and one from the far
	// corner of the coordinate range that is mostly outside.
	task automatic test_line_draw();
		send_item(make_item(OP_LINE, 10, 10, 10, 10, -1));
		send_item(make_item(OP_LINE, 0, 8, 127, 20, -1));
		send_item(make_item(OP_LINE, 5, 0, 9, 63, -1));
		send_item(make_item(OP_LINE, 0, 0, 63, 63, -1));
		send_item(make_item(OP_LINE, 127, 63, 0, 30, -1));
		send_item(make_item(OP_LINE, 200, 70, 100, 10, -1));
		send_item(make_item(OP_LINE, 255, 255, 0, 0, -1));
		send_item(make_item(OP_READ, -1, -1, -1, -1, COLUMNS + 10));
		send_item(make_item(OP_READ, -1, -1, -1, -1, 7 * COLUMNS + 63));
		send_item(make_item(OP_READ, -1, -1, -1, -1, COLUMNS + 100));
	endtask

	// A clear must wipe everything drawn so far, including the last byte.
	task automatic test_store_clear();
		send_item(make_item(OP_CLEAR, -1, -1, -1, -1, -1));
		send_item(make_item(OP_READ, -1, -1, -1, -1, 0));
		send_item(make_item(OP_READ, -1, -1, -1, -1, STORE_BYTES - 1));
	endtask

	// Random traffic. Most lines and pixels fall inside the store and most reads land in
	// the area that was just drawn, so the reads see real content; the rest uses the full
	// field ranges. Clears are rare because each one costs a full pass over the store.
	// Every third stretch of 150 items runs with no gaps on either side.
	task automatic test_random_traffic(int count);
		raster_req_t req;
		int sel, rx, ry;
		for (int i = 0; i < count; i++) begin
			idle_enabled = ((i / 150) % 3) != 2;
			sel = $urandom_range(0, 99);
			if (sel < 2) begin
				req = make_item(OP_CLEAR, -1, -1, -1, -1, -1);
			end else if (sel < 32) begin
				if ($urandom_range(0, 4) != 0) begin
					last_xa = $urandom_range(0, COLUMNS - 1);
					last_ya = $urandom_range(0, ROWS - 1);
					last_xb = $urandom_range(0, COLUMNS - 1);
					last_yb = $urandom_range(0, ROWS - 1);
					req = make_item(OP_LINE, last_xa, last_ya, last_xb, last_yb, -1);
				end else begin
					req = make_item(OP_LINE, -1, -1, -1, -1, -1);
				end
			end else if (sel < 55) begin
				if ($urandom_range(0, 4) != 0) begin
					last_xa = $urandom_range(0, COLUMNS - 1);
					last_ya = $urandom_range(0, ROWS - 1);
					last_xb = last_xa;
					last_yb = last_ya;
					req = make_item(OP_SET, last_xa, last_ya, -1, -1, -1);
				end else begin
					req = make_item(OP_SET, -1, -1, -1, -1, -1);
				end
			end else if ($urandom_range(0, 9) < 6) begin
				rx = (last_xa < last_xb) ? $urandom_range(last_xa, last_xb)
					: $urandom_range(last_xb, last_xa);
				ry = (last_ya < last_yb) ? $urandom_range(last_ya, last_yb)
					: $urandom_range(last_yb, last_ya);
				req = make_item(OP_READ, -1, -1, -1, -1, (ry >> 3) * COLUMNS + rx);
			end else begin
				req = make_item(OP_READ, -1, -1, -1, -1, -1);
			end
			send_item(req);
		end
		idle_enabled = 1'b1;
	endtask

	// Receiver side: random stalls on the result channel, each a stretch of random length
	// that may run straight into the next one.
	initial begin : rsp_stall_gen
		int n;
		forever begin
			@(negedge clk);
			n = gap_cycles();
			if (n == 0) begin
				rsp_stall = 1'b0;
			end else begin
				rsp_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Result checker: every result taken is compared with the oldest one awaited.
	always @(posedge clk) begin : rsp_check
		raster_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing awaited: read_byte %0h, status %0b",
					read_byte, status);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				checked_count++;
				if (read_byte !== want.read_byte) begin
					$error("read_byte: expected %0h, actual %0h", want.read_byte, read_byte);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0b, actual %0b", want.status, status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		// The model starts from the cleared state that the block reaches after reset.
		foreach (frame_model[i]) frame_model[i] = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// The clearing pass after reset holds the request channel off on its own,
		// so the first item simply waits in the handshake.
		test_reset_state();
		test_pixel_set();
		test_line_draw();
		test_store_clear();
		test_random_traffic(1050);

		@(negedge clk);
		req_valid = 1'b0;

		// Drain: every result must come back, then a quiet stretch catches extras.
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			fail_count++;
		end
		$display("Ran %0d clears, %0d pixel sets (%0d out of range), %0d lines, %0d reads.",
			clear_count, set_count, reject_count, line_count, read_count);
		$display("Checked %0d results in %0d cycles with %0d mismatches.",
			checked_count, cycle_count, fail_count);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// File: line_raster_page_framebuffer.f
src/lrpf_pkg.sv
src/lrpf_store.sv
src/lrpf_step.sv
src/line_raster_page_framebuffer.sv
src/lrpf_chk.sv
sim/tb.sv
